// ===== rtl/core/b64d_pkg.sv =====
// shared types and constants of the base64 decoder
`default_nettype none

package b64d_pkg;

  // default number of entries in the command queue between front and back
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  // one command: the results caused by one accepted character
  typedef struct packed {
    logic [7:0] b0;        // first result byte
    logic [7:0] b1;        // second result byte
    logic [7:0] b2;        // third result byte
    logic [1:0] last_idx;  // index of the final result, 0..2
    logic       has_byte;  // 0 for a bare end-of-string marker
    logic       ends;      // final result closes the string
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// front part: character transfer, alphabet mapping, group assembly and command build
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last_char,
  input  wire logic       q_full,
  output cmd_t            cmd,
  output logic            cmd_push
);

  logic [5:0] store_r [3];
  logic [1:0] fill_r, fill_nxt;
  logic       halted_r, halted_nxt;
  logic       accept;
  logic       bad;
  logic [5:0] v;
  logic [5:0] e0, e1, e2;
  logic       st_we;
  logic       flush;
  logic [1:0] f;
  logic [1:0] k;

  // map one character of the standard alphabet to its sextet
  always_comb begin
    logic [7:0] d;
    d   = 8'h00;
    bad = 1'b0;
    if (in_char inside {[8'h41:8'h5A]}) begin
      d = in_char - 8'h41;
    end else if (in_char inside {[8'h61:8'h7A]}) begin
      d = in_char - 8'h61 + 8'd26;
    end else if (in_char inside {[8'h30:8'h39]}) begin
      d = in_char - 8'h30 + 8'd52;
    end else if (in_char == 8'h2B) begin
      d = 8'd62;
    end else if (in_char == 8'h2F) begin
      d = 8'd63;
    end else begin
      bad = 1'b1;
    end
    v = d[5:0];
  end

  assign accept = push && !q_full;

  // group as it stands with the new sextet in its slot
  assign e0 = (fill_r == 2'd0) ? v : store_r[0];
  assign e1 = (fill_r == 2'd1) ? v : store_r[1];
  assign e2 = (fill_r == 2'd2) ? v : store_r[2];

  // command build and state update
  always_comb begin
    cmd          = '0;
    cmd.b0       = {e0, e1[5:4]};
    cmd.b1       = {e1[3:0], e2[5:2]};
    cmd.b2       = {e2[1:0], v};
    cmd.has_byte = 1'b1;
    fill_nxt     = fill_r;
    halted_nxt   = halted_r;
    st_we        = 1'b0;
    flush        = 1'b0;
    f            = fill_r;
    k            = 2'd0;
    if (accept) begin
      if (!halted_r) begin
        if (bad) begin
          halted_nxt = 1'b1;
          flush      = 1'b1;
        end else if (fill_r == 2'd3) begin
          k        = 2'd3;
          f        = 2'd0;
          fill_nxt = 2'd0;
        end else begin
          st_we    = 1'b1;
          f        = fill_r + 2'd1;
          fill_nxt = f;
        end
        if (in_last_char || flush) begin
          if (f >= 2'd2) begin
            k = f - 2'd1;
          end
          fill_nxt = 2'd0;
        end
      end
      if (in_last_char) begin
        if (k == 2'd0) begin
          k            = 2'd1;
          cmd.has_byte = 1'b0;
          cmd.b0       = 8'h00;
        end
        cmd.ends   = 1'b1;
        fill_nxt   = 2'd0;
        halted_nxt = 1'b0;
      end
    end
    cmd.last_idx = k - 2'd1;
  end

  assign cmd_push = (k != 2'd0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 2'd0;
      halted_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      halted_r <= halted_nxt;
    end
  end

  // sextet store, written in the slot of the group in progress
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_r[fill_r] <= v;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// short command queue between front and back
`default_nettype none

module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_data,
  output logic      nonempty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// back part: expands each command into one result transfer per cycle while pop is high
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       q_data,
  input  wire logic       q_nonempty,
  output logic            q_rd,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_run_last,
  output logic            out_stream_end
);

  cmd_t       cmd_r, cmd_nxt;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       run_last;
  logic       done;

  assign empty    = !vld_r;
  assign run_last = (idx_r == cmd_r.last_idx);
  assign done     = vld_r && pop && run_last;
  assign q_rd     = q_nonempty && (!vld_r || done);

  // result fields from the command in hand
  always_comb begin
    case (idx_r)
      2'd0:    out_byte = cmd_r.b0;
      2'd1:    out_byte = cmd_r.b1;
      default: out_byte = cmd_r.b2;
    endcase
  end

  assign out_byte_valid = cmd_r.has_byte;
  assign out_run_last   = run_last;
  assign out_stream_end = run_last && cmd_r.ends;

  // load the next command or step through the current one
  always_comb begin
    cmd_nxt = cmd_r;
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (q_rd) begin
      cmd_nxt = q_data;
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (vld_r && pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

`ifndef SYNTH
  // result index never runs past the end of its command
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (idx_r <= cmd_r.last_idx))
    else $error("result index past end of command");

  // a transfer that is not the final one keeps the command and advances
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && pop && !run_last) |=> (vld_r && (idx_r == $past(idx_r) + 2'd1)))
    else $error("command lost or index not advanced");

  // a bare marker is always a single result
  a_marker_single: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !cmd_r.has_byte) |-> (cmd_r.last_idx == 2'd0 && cmd_r.ends))
    else $error("bare marker with more than one result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/base64_decoder.sv =====
// Streaming base64 decoder, one character per transfer, with a queue interface on both sides.
// The block takes one character per cycle while full is low; a command for each character
// that causes results enters a queue of QUEUE_DEPTH entries and the back part delivers
// results at one per cycle while pop is high, so a character finishing a group delivers its
// three bytes one after another. The input side, one character per cycle, sets the sustained
// rate: a string never causes more results than it has characters, so full rises only when
// the queue fills behind a stalled consumer. A command passes through the queue and is
// registered in the back part before its first result shows. A string ends with its last
// character: the final result carries stream_end, and a bare marker (byte_valid low) stands
// in when there is no byte to deliver.
`default_nettype none

module base64_decoder import b64d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last_char,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_run_last,
  output logic            out_stream_end
);

  cmd_t f_cmd;
  logic f_push;
  logic q_full;
  cmd_t q_data;
  logic q_nonempty;
  logic q_rd;

  assign full = q_full;

  // character transfer and classification
  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .cmd          (f_cmd),
    .cmd_push     (f_push)
  );

  // decoupling queue
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_data  (f_cmd),
    .full     (q_full),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .nonempty (q_nonempty)
  );

  // result delivery
  b64d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_data),
    .q_nonempty     (q_nonempty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

`default_nettype wire

// ===== dv/b64d_decode_check.sv =====
// checker for the base64 decoder: predicts the decoded bytes and compares each result transfer
module b64d_decode_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_run_last,
  input  logic       out_stream_end,
  output int         fail_count,
  output int         pending
);

  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SLASH = "/";

  // one decoded result as the block should deliver it
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       item_end;
    logic       text_end;
  } dec_byte_t;

  dec_byte_t  byte_q[$];

  // predictor state: sextets of the open group, fill level, halt flag
  logic [2:0][5:0] held_sextets;
  logic [1:0]      fill_lvl;
  logic            stopped;

  // bit 6 set when the character lies outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
    if (c == CH_PLUS)         return {1'b0, 6'd62};
    if (c == CH_SLASH)        return {1'b0, 6'd63};
    return 7'h40;
  endfunction

  // byte k of a group, taken straight from the 24-bit sextet concatenation
  function automatic logic [7:0] group_byte(input logic [3:0][5:0] s, input int k);
    case (k)
      0:       return {s[0], s[1][5:4]};
      1:       return {s[1][3:0], s[2][5:2]};
      default: return {s[2][1:0], s[3]};
    endcase
  endfunction

  // work out the results of one accepted character and queue them
  task automatic decode_char(input logic [7:0] c, input logic is_last);
    logic [6:0]      v;
    logic [3:0][5:0] s;
    logic            flush;
    dec_byte_t       res [3];
    int              n;
    n = 0;
    flush = 1'b0;
    s = {6'd0, held_sextets};
    if (!stopped) begin
      v = sextet_of(c);
      if (v[6]) begin
        stopped = 1'b1;
        flush = 1'b1;
      end else if (fill_lvl == 2'd3) begin
        s[3] = v[5:0];
        for (int k = 0; k < 3; k++) begin
          res[n] = '{group_byte(s, k), 1'b1, 1'b0, 1'b0};
          n++;
        end
        fill_lvl = 2'd0;
      end else begin
        held_sextets[fill_lvl] = v[5:0];
        s[fill_lvl] = v[5:0];
        fill_lvl = fill_lvl + 2'd1;
      end
      if (is_last) flush = 1'b1;
      // partial group: two sextets give one byte, three give two
      if (flush) begin
        for (int k = 0; k + 1 < int'(fill_lvl); k++) begin
          res[n] = '{group_byte(s, k), 1'b1, 1'b0, 1'b0};
          n++;
        end
        fill_lvl = 2'd0;
        held_sextets = '0;
      end
    end
    // end of text: bare marker if nothing else came out, then clear
    if (is_last) begin
      if (n == 0) begin
        res[n] = '{8'h00, 1'b0, 1'b0, 1'b0};
        n++;
      end
      res[n-1].text_end = 1'b1;
      stopped = 1'b0;
      fill_lvl = 2'd0;
      held_sextets = '0;
    end
    if (n > 0) res[n-1].item_end = 1'b1;
    for (int k = 0; k < n; k++) byte_q.insert(byte_q.size(), res[k]);
  endtask

  // compare result transfers, then predict from input transfers
  always @(posedge clk) begin
    dec_byte_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      byte_q.delete();
      held_sextets = '0;
      fill_lvl = 2'd0;
      stopped = 1'b0;
      fail_count <= 0;
    end else begin
      if (pop && !empty) begin
        if (byte_q.size() == 0) begin
          $error("result with nothing expected: out_byte %02h valid %0b", out_byte,
                 out_byte_valid);
          errs++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte_valid !== want.has_byte) begin
            $error("out_byte_valid expected %0b got %0b", want.has_byte, out_byte_valid);
            errs++;
          end
          if (out_byte !== want.data) begin
            $error("out_byte expected %02h got %02h", want.data, out_byte);
            errs++;
          end
          if (out_run_last !== want.item_end) begin
            $error("out_run_last expected %0b got %0b", want.item_end, out_run_last);
            errs++;
          end
          if (out_stream_end !== want.text_end) begin
            $error("out_stream_end expected %0b got %0b", want.text_end, out_stream_end);
            errs++;
          end
        end
      end
      if (push && !full) decode_char(in_char, in_last_char);
      fail_count <= fail_count + errs;
    end
    pending <= byte_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the base64 decoder: clock, reset, character stimulus and verdict
module tb_top;

  localparam int N_ITEMS     = 310;
  localparam int CALM_FROM   = 270;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  localparam logic [7:0] CH_PAD = "=";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       in_last_char = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_stream_end;

  int fail_count;
  int pending;
  int chars_sent = 0;
  int pop_hold = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  base64_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_char        (in_char),
    .in_last_char   (in_last_char),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

  b64d_decode_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_char        (in_char),
    .in_last_char   (in_last_char),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // result side: pop held low in random bursts until the calm tail
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_hold <= $urandom_range(0, 14);
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // character of the alphabet for a sextet value
  function automatic logic [7:0] alpha_char(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  // one character transfer, with an optional gap in front of it
  task automatic push_char(input logic [7:0] c, input logic is_last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    in_char <= c;
    in_last_char <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
    calm = (chars_sent >= CALM_FROM);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // random text: mostly clean or padded, some corrupted, some pure noise
  task automatic push_random_text();
    int         kind;
    int         len;
    int         bad_at;
    int         pad_n;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    len = $urandom_range(1, 14);
    bad_at = (kind == 7 || kind == 8) ? $urandom_range(0, len - 1) : len;
    pad_n = 0;
    if (kind == 5 || kind == 6) begin
      pad_n = $urandom_range(1, 2);
      if (pad_n > len - 1) pad_n = len - 1;
    end
    for (int i = 0; i < len; i++) begin
      if (kind == 9 || i == bad_at) c = 8'($urandom_range(0, 255));
      else if (i >= len - pad_n) c = CH_PAD;
      else c = alpha_char($urandom_range(0, 63));
      push_char(c, i == len - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full group on the last character
    push_text("QUJD");
    // group, then a single leftover sextet that is dropped
    push_text("+/9zA");
    // three and two leftover sextets flushed at the end
    push_text("Za0");
    push_text("az");
    // nothing to deliver: bare end marker
    push_text("=");
    // halt with a partial group on the last character
    push_text("AB=");
    // halt mid-text, characters after it ignored, end on a control byte
    push_char("A", 1'b0);
    push_char("B", 1'b0);
    push_char("@", 1'b0);
    push_char(8'hff, 1'b0);
    push_char(8'h00, 1'b1);
    // lone sextet, and a high byte as the only character
    push_text("/");
    push_char(8'h80, 1'b1);

    // random texts
    while (chars_sent < N_ITEMS) push_random_text();
    push <= 1'b0;

    // drain, then give stray results a chance to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_decoder.sv
dv/b64d_decode_check.sv
dv/tb_top.sv
